/* src/euzxz_pkg.sv */
// Shared constants, types and the arctangent table for the z-x-z rotation matrix block.
`timescale 1ns / 1ps

package euzxz_pkg;

    localparam int ANGLE_BITS      = 16;
    localparam int COEF_BITS       = 16;
    localparam int TRIG_ITERATIONS = 16;

    localparam int PHASE_W    = 32;                // one full turn = 2^32
    localparam int CORDIC_W   = 34;                // Q30 datapath with headroom
    localparam int TRIG_W     = 32;                // sine / cosine in Q30
    localparam int PROD_W     = 2 * TRIG_W;        // Q60 products and sums
    localparam int Q30_SHIFT  = 30;
    localparam int COEF_FRAC  = COEF_BITS - 2;
    localparam int ROUND_SH   = 60 - COEF_FRAC;

    localparam int CORDIC_LAT = TRIG_ITERATIONS + 2;
    localparam int PIPE_LAT   = CORDIC_LAT + 4;

    localparam int IN_TDATA_W  = ((3 * ANGLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((9 * COEF_BITS + 7) / 8) * 8;

    typedef logic signed [CORDIC_W-1:0]  t_cordic;
    typedef logic signed [TRIG_W-1:0]    t_trig;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [COEF_BITS-1:0] t_coef;

    localparam t_cordic CORDIC_GAIN = t_cordic'(34'sd652032874);

    // arctangent of 2^-i in phase units, rounded to nearest
    localparam logic [31:0] ATAN_LUT [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'd41722,    32'd20861,
        32'd10430,    32'd5215,     32'd2608,     32'd1304,
        32'd652,      32'd326,      32'd163,      32'd81,
        32'd41,       32'd20,       32'd10,       32'd5,
        32'd3,        32'd1,        32'd1,        32'd0
    };

endpackage

/* src/euzxz_cordic.sv */
// Pipelined rotation-mode CORDIC: one binary angle in, Q30 sine and cosine out.
`timescale 1ns / 1ps

module euzxz_cordic (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [euzxz_pkg::ANGLE_BITS-1:0] i_angle,
    output euzxz_pkg::t_trig                 o_sin,
    output euzxz_pkg::t_trig                 o_cos
);
    import euzxz_pkg::*;

    localparam int N = TRIG_ITERATIONS;

    logic [PHASE_W-1:0]        w_phase;
    logic                      w_neg;
    logic signed [PHASE_W-1:0] w_zred;

    t_cordic r_x   [0:N];
    t_cordic r_y   [0:N];
    t_cordic r_z   [0:N];
    logic    r_neg [0:N];

    t_cordic w_cos_fin;
    t_cordic w_sin_fin;
    t_trig   r_sin;
    t_trig   r_cos;

    assign w_phase = PHASE_W'(i_angle) << (PHASE_W - ANGLE_BITS);

    // outside [-pi/2, pi/2): move by pi, negate the results at the end
    assign w_neg  = w_phase[PHASE_W-1] ^ w_phase[PHASE_W-2];
    assign w_zred = {w_phase[PHASE_W-1] ^ w_neg, w_phase[PHASE_W-2:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= CORDIC_W'(w_zred);
            r_neg[0] <= w_neg;
        end
    end

    for (genvar gi = 0; gi < N; gi++) begin : g_iter
        localparam int      K    = (gi > 31) ? 31 : gi;
        localparam t_cordic ATAN = t_cordic'(ATAN_LUT[K]);

        t_cordic w_dx;
        t_cordic w_dy;

        assign w_dx = r_y[gi] >>> K;
        assign w_dy = r_x[gi] >>> K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[gi][CORDIC_W-1]) begin
                    r_x[gi+1] <= r_x[gi] - w_dx;
                    r_y[gi+1] <= r_y[gi] + w_dy;
                    r_z[gi+1] <= r_z[gi] - ATAN;
                end else begin
                    r_x[gi+1] <= r_x[gi] + w_dx;
                    r_y[gi+1] <= r_y[gi] - w_dy;
                    r_z[gi+1] <= r_z[gi] + ATAN;
                end
                r_neg[gi+1] <= r_neg[gi];
            end
        end
    end

    assign w_cos_fin = r_neg[N] ? -r_x[N] : r_x[N];
    assign w_sin_fin = r_neg[N] ? -r_y[N] : r_y[N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= t_trig'(w_cos_fin);
            r_sin <= t_trig'(w_sin_fin);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

/* src/euler_zxz_rotation_matrix.sv */
// Top level: z-x-z Euler angle rotation matrix, fully pipelined stream block.
// Throughput: one item per cycle; the depth is set by one pipeline stage per
// CORDIC step plus reduction, sign fix, two multiply, sum and round stages.
// The whole pipeline holds when the output register is full and not taken.
// Reset (synchronous, active low) clears the valid bits only.
`timescale 1ns / 1ps

module euler_zxz_rotation_matrix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0: phi_angle, theta_angle, psi_angle
    input  logic [euzxz_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: func
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata from bit 0: m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [euzxz_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import euzxz_pkg::*;

    localparam int L = PIPE_LAT;
    localparam int S_SUM = L - 2;

    localparam t_prod ROUND_HALF = t_prod'(64'd1 << (ROUND_SH - 1));
    localparam t_prod LIM_WIDE   = t_prod'(64'd1 << COEF_FRAC);
    localparam t_coef C_LIM      = t_coef'(LIM_WIDE);

    function automatic t_prod mul_q30(input t_prod p, input t_trig c);
        t_trig t;
        t = t_trig'(p >>> Q30_SHIFT);
        return PROD_W'(t) * PROD_W'(c);
    endfunction

    logic         w_adv;
    logic [L-1:0] r_vld;
    logic         r_func [0:L-2];

    t_trig w_sph, w_cph, w_sth, w_cth, w_sps, w_cps;

    // first product stage
    t_prod r_p_cc, r_p_cs, r_p_ss_th, r_p_sc, r_p_ss, r_p_c_th, r_p_th_s, r_p_th_c;
    t_trig r_cth1;

    // second product stage
    t_prod r_q1, r_q2, r_q3, r_q4;
    t_prod r_p2_cc, r_p2_cs, r_p2_ss_th, r_p2_sc, r_p2_ss, r_p2_c_th, r_p2_th_s, r_p2_th_c;
    t_trig r_cth2;

    t_prod r_a   [0:8];
    t_prod w_rnd [0:8];
    t_coef w_sat [0:8];
    t_coef w_sel [0:8];
    t_coef r_m   [0:8];

    assign w_adv         = !r_vld[L-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[L-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_func[0] <= s_axis_tuser;
            for (int k = 1; k < L - 1; k++) begin
                r_func[k] <= r_func[k-1];
            end
        end
    end

    euzxz_cordic u_cordic_phi (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (s_axis_tdata[ANGLE_BITS-1:0]),
        .o_sin   (w_sph),
        .o_cos   (w_cph)
    );

    euzxz_cordic u_cordic_theta (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .o_sin   (w_sth),
        .o_cos   (w_cth)
    );

    euzxz_cordic u_cordic_psi (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
        .o_sin   (w_sps),
        .o_cos   (w_cps)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_cc    <= PROD_W'(w_cps) * PROD_W'(w_cph);
            r_p_cs    <= PROD_W'(w_cps) * PROD_W'(w_sph);
            r_p_ss_th <= PROD_W'(w_sps) * PROD_W'(w_sth);
            r_p_sc    <= PROD_W'(w_sps) * PROD_W'(w_cph);
            r_p_ss    <= PROD_W'(w_sps) * PROD_W'(w_sph);
            r_p_c_th  <= PROD_W'(w_cps) * PROD_W'(w_sth);
            r_p_th_s  <= PROD_W'(w_sth) * PROD_W'(w_sph);
            r_p_th_c  <= PROD_W'(w_sth) * PROD_W'(w_cph);
            r_cth1    <= w_cth;
        end
    end

    // three-factor terms: truncate the pair product to Q30, then times cos(theta)
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q1       <= mul_q30(r_p_ss, r_cth1);
            r_q2       <= mul_q30(r_p_sc, r_cth1);
            r_q3       <= mul_q30(r_p_cs, r_cth1);
            r_q4       <= mul_q30(r_p_cc, r_cth1);
            r_p2_cc    <= r_p_cc;
            r_p2_cs    <= r_p_cs;
            r_p2_ss_th <= r_p_ss_th;
            r_p2_sc    <= r_p_sc;
            r_p2_ss    <= r_p_ss;
            r_p2_c_th  <= r_p_c_th;
            r_p2_th_s  <= r_p_th_s;
            r_p2_th_c  <= r_p_th_c;
            r_cth2     <= r_cth1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a[0] <= r_p2_cc - r_q1;
            r_a[1] <= r_p2_cs + r_q2;
            r_a[2] <= r_p2_ss_th;
            r_a[3] <= -r_p2_sc - r_q3;
            r_a[4] <= -r_p2_ss + r_q4;
            r_a[5] <= r_p2_c_th;
            r_a[6] <= r_p2_th_s;
            r_a[7] <= -r_p2_th_c;
            r_a[8] <= PROD_W'(r_cth2) <<< Q30_SHIFT;
        end
    end

    // round half up, then clamp to plus or minus one
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_rnd[k] = (r_a[k] + ROUND_HALF) >>> ROUND_SH;
            priority if (w_rnd[k] > LIM_WIDE) begin
                w_sat[k] = C_LIM;
            end else if (w_rnd[k] < -LIM_WIDE) begin
                w_sat[k] = -C_LIM;
            end else begin
                w_sat[k] = t_coef'(w_rnd[k]);
            end
        end
    end

    // body rotation gives the transposed matrix
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_sel[r*3+c] = r_func[S_SUM] ? w_sat[c*3+r] : w_sat[r*3+c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 9; k++) begin
                r_m[k] <= w_sel[k];
            end
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < 9; k++) begin
            m_axis_tdata[k*COEF_BITS +: COEF_BITS] = r_m[k];
        end
    end

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_m[0] <= C_LIM && r_m[0] >= -C_LIM &&
                           r_m[4] <= C_LIM && r_m[4] >= -C_LIM &&
                           r_m[8] <= C_LIM && r_m[8] >= -C_LIM))
        else $error("diagonal coefficient outside plus or minus one");
`endif

endmodule

/* verif/tb_euler_zxz_rotation_matrix.sv */
// Self-checking stream testbench for the z-x-z Euler angle rotation matrix block.
`timescale 1ns / 1ps

module tb_euler_zxz_rotation_matrix;
    import euzxz_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RANDOM_REQS = 500;
    localparam int FRAC        = COEF_BITS - 2;
    localparam int SAT_SHIFT   = 60 - FRAC;

    localparam bit ROT_AXES = 1'b0;   // rotate the axes, body fixed
    localparam bit ROT_BODY = 1'b1;   // rotate the body, transposed matrix

    localparam longint HALF_TURN    = 64'sh8000_0000;
    localparam longint QUARTER_TURN = 64'sh4000_0000;
    localparam longint UNIT_Q30     = 64'sh4000_0000;
    localparam longint TRIG_START_X = 64'sd652032874;

    // arctangent of 2^-i as a fraction of a full turn times 2^32
    localparam longint ARCTAN_STEPS [32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81,
        41, 20, 10, 5,
        3, 1, 1, 0
    };

    localparam logic [ANGLE_BITS-1:0] EDGE_ANGLES [10] = '{
        16'h0000, 16'h4000, 16'hC000, 16'hBFFF, 16'h3FFF,
        16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h2000
    };

    typedef struct {
        t_coef entry [9];
    } t_matrix;

    class rotation_scoreboard;
        t_matrix want_q [$];
        int      mismatches;
        int      matrices_seen;
        int      body_reqs;
        int      axes_reqs;

        function new();
            mismatches    = 0;
            matrices_seen = 0;
            body_reqs     = 0;
            axes_reqs     = 0;
        endfunction

        // rotation-mode CORDIC with reduction into [-pi/2, pi/2)
        function void sin_cos_q30(input logic [ANGLE_BITS-1:0] ang,
                                  output longint sn, output longint cs);
            logic [31:0] ph;
            longint z, x, y, dx, dy;
            int k;
            bit flip;
            ph   = 32'(ang) << (32 - ANGLE_BITS);
            z    = longint'($signed(ph));
            flip = 1'b0;
            if (z >= QUARTER_TURN) begin
                z -= HALF_TURN;
                flip = 1'b1;
            end else if (z < -QUARTER_TURN) begin
                z += HALF_TURN;
                flip = 1'b1;
            end
            x = TRIG_START_X;
            y = 0;
            for (int i = 0; i < TRIG_ITERATIONS; i++) begin
                k  = (i > 31) ? 31 : i;
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= ARCTAN_STEPS[k];
                end else begin
                    x += dx;
                    y -= dy;
                    z += ARCTAN_STEPS[k];
                end
            end
            cs = flip ? -x : x;
            sn = flip ? -y : y;
        endfunction

        function longint triple_q60(longint a, longint b, longint c);
            return ((a * b) >>> 30) * c;
        endfunction

        function t_coef round_sat(longint v);
            longint r;
            longint lim;
            lim = 64'sd1 <<< FRAC;
            r   = (v + (64'sd1 <<< (SAT_SHIFT - 1))) >>> SAT_SHIFT;
            if (r > lim)
                r = lim;
            if (r < -lim)
                r = -lim;
            return t_coef'(r);
        endfunction

        function void note_request(logic [ANGLE_BITS-1:0] phi, logic [ANGLE_BITS-1:0] theta,
                                   logic [ANGLE_BITS-1:0] psi, bit mode);
            longint sph, cph, sth, cth, sps, cps;
            longint a [3][3];
            t_matrix m;
            sin_cos_q30(phi, sph, cph);
            sin_cos_q30(theta, sth, cth);
            sin_cos_q30(psi, sps, cps);
            a[0][0] = cps * cph - triple_q60(sph, sps, cth);
            a[0][1] = cps * sph + triple_q60(cph, sps, cth);
            a[0][2] = sps * sth;
            a[1][0] = -(sps * cph) - triple_q60(sph, cps, cth);
            a[1][1] = -(sps * sph) + triple_q60(cph, cps, cth);
            a[1][2] = cps * sth;
            a[2][0] = sth * sph;
            a[2][1] = -(sth * cph);
            a[2][2] = cth * UNIT_Q30;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    m.entry[r*3 + c] = round_sat((mode == ROT_BODY) ? a[c][r] : a[r][c]);
            if (mode == ROT_BODY)
                body_reqs++;
            else
                axes_reqs++;
            want_q.push_back(m);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            t_matrix m;
            t_coef got;
            matrices_seen++;
            if (want_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: matrix arrived with nothing outstanding, data %h",
                         $time, data);
                return;
            end
            m = want_q.pop_front();
            for (int j = 0; j < 9; j++) begin
                got = t_coef'(data[j*COEF_BITS +: COEF_BITS]);
                if (got !== m.entry[j]) begin
                    mismatches++;
                    $display("%0t ns: m%0d%0d expected %0d, actual %0d",
                             $time, j / 3, j % 3, m.entry[j], got);
                end
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // phi_angle, theta_angle, psi_angle
    logic                   s_axis_tuser  = 1'b0; // func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // m00 .. m22, row major

    rotation_scoreboard sb;
    bit calm = 1'b0;
    int directed_reqs = 0;
    int random_reqs   = 0;

    euler_zxz_rotation_matrix u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    task automatic send_angles(input logic [ANGLE_BITS-1:0] phi,
                               input logic [ANGLE_BITS-1:0] theta,
                               input logic [ANGLE_BITS-1:0] psi, input bit mode);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {psi, theta, phi};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_request(phi, theta, psi, mode);
    endtask

    task automatic maybe_idle();
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom});
            s_axis_tuser  <= 1'($urandom_range(0, 1));
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold the sender until every matrix in flight has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [ANGLE_BITS-1:0] pick_angle();
        if ($urandom_range(0, 3) == 0)
            return EDGE_ANGLES[$urandom_range(0, 9)];
        return ANGLE_BITS'($urandom);
    endfunction

    // receiver: take results and stall in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [ANGLE_BITS-1:0] d_phi   [20] = '{
            16'h0000, 16'h0000, 16'h4000, 16'hC000, 16'hBFFF, 16'h3FFF, 16'h8000,
            16'h7FFF, 16'h0001, 16'hFFFF, 16'h2000, 16'h8000, 16'h0000, 16'h5555,
            16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h1234, 16'hE000};
        logic [ANGLE_BITS-1:0] d_theta [20] = '{
            16'h0000, 16'h0000, 16'h4000, 16'hC000, 16'hBFFF, 16'h3FFF, 16'h8000,
            16'h7FFF, 16'hFFFF, 16'h0001, 16'h1555, 16'h0000, 16'h8000, 16'hD555,
            16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000};
        logic [ANGLE_BITS-1:0] d_psi   [20] = '{
            16'h0000, 16'h0000, 16'h4000, 16'hC000, 16'hBFFF, 16'h3FFF, 16'h8000,
            16'h7FFF, 16'h0001, 16'hFFFF, 16'hE000, 16'h4000, 16'h0000, 16'h3039,
            16'h0F0F, 16'hF0F0, 16'h0000, 16'hFFFF, 16'h8000, 16'h3FFF};
        bit                    d_mode  [20] = '{
            ROT_AXES, ROT_BODY, ROT_AXES, ROT_BODY, ROT_AXES, ROT_BODY, ROT_AXES,
            ROT_BODY, ROT_AXES, ROT_BODY, ROT_AXES, ROT_BODY, ROT_AXES, ROT_BODY,
            ROT_AXES, ROT_BODY, ROT_AXES, ROT_BODY, ROT_BODY, ROT_AXES};

        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, quarter-turn boundaries, half turn, saturation
        for (int i = 0; i < 20; i++) begin
            send_angles(d_phi[i], d_theta[i], d_psi[i], d_mode[i]);
            directed_reqs++;
            maybe_idle();
        end
        drain();

        for (int i = 0; i < RANDOM_REQS; i++) begin
            calm = (i >= 150 && i < 230) || (i >= RANDOM_REQS - 80);
            if (i == 300)
                drain();
            send_angles(pick_angle(), pick_angle(), pick_angle(), 1'($urandom_range(0, 1)));
            random_reqs++;
            maybe_idle();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);

        $display("Covered %0d directed and %0d random angle triples (%0d axes, %0d body).",
                 directed_reqs, random_reqs, sb.axes_reqs, sb.body_reqs);
        $display("Checked %0d matrices under random stalls on both sides, %0d mismatches.",
                 sb.matrices_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 250000);
        $display("%0t ns: timeout, %0d matrices still outstanding", $time, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
